// ===== rtl/text_console_writer_assert.svh =====
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TCW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PRINT,
    CMD_BS,
    CMD_TAB,
    CMD_CR,
    CMD_LF,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } back_state_t;

endpackage

// ===== rtl/tcw_front.sv =====
module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic [MODE_W-1:0] in_tuser,   // mode[1:0]
  input  logic              q_full,
  input  logic              init_busy,
  output logic              q_push,
  output cmd_t              q_cmd
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [CHAR_W-1:0] ch;
  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              printable;

  assign ch        = in_tdata[CHAR_W-1:0];
  assign idx       = in_tdata[CHAR_W +: IDX_W];
  assign in_range  = 32'(idx) < CELLS;
  assign printable = (ch >= CH_SPACE) && (ch <= CH_LAST_PRINT);

  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_cmd.char_code  = ch;
    q_cmd.cell_index = idx;
    q_cmd.kind       = CMD_NOP;
    case (in_tuser)
      MODE_PUT: begin
        if (printable) begin
          q_cmd.kind = CMD_PRINT;
        end else begin
          case (ch)
            CH_BS:   q_cmd.kind = CMD_BS;
            CH_TAB:  q_cmd.kind = CMD_TAB;
            CH_CR:   q_cmd.kind = CMD_CR;
            CH_LF:   q_cmd.kind = CMD_LF;
            default: q_cmd.kind = CMD_NOP;
          endcase
        end
      end
      MODE_CLEAR: q_cmd.kind = CMD_CLEAR;
      MODE_READ:  q_cmd.kind = in_range ? CMD_READ : CMD_NOP;
      default:    q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/tcw_fifo.sv =====
`include "text_console_writer_assert.svh"

module tcw_fifo
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `TCW_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
  `TCW_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, valid)
  `TCW_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `TCW_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, valid)

endmodule

// ===== rtl/tcw_back.sv =====
`include "text_console_writer_assert.svh"

module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              init_busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
  localparam int ROW_W  = $clog2(ROWS + 1);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt, col_put;
  logic [ROW_W-1:0]  row_r, row_nxt, row_put;
  logic [ATTR_W-1:0] attr_r;
  logic              init_r, init_nxt;
  logic              scroll_r, scroll_nxt;
  logic              need_scroll;
  logic              is_put;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] fill_word;
  logic [ADDR_W-1:0] cur_addr;

  logic              out_valid_r, out_valid_nxt;
  logic [LOC_W-1:0]  out_loc_r, out_loc_nxt;
  logic [CELL_W-1:0] out_data_r, out_data_nxt;
  logic              out_scr_r, out_scr_nxt;
  logic              load;

  assign init_busy  = init_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_scr_r, out_data_r, out_loc_r};

  assign q_pop     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_tready);
  assign is_put    = (q_cmd.kind != CMD_CLEAR) && (q_cmd.kind != CMD_READ);
  assign fill_word = init_r ? RESET_BLANK : {attr_r, CH_SPACE};
  assign cur_addr  = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));

  // cursor update for the put command
  always_comb begin
    col_put = col_r;
    row_put = row_r;
    case (q_cmd.kind)
      CMD_PRINT: col_put = col_r + 1'b1;
      CMD_BS:    col_put = (col_r != '0) ? col_r - 1'b1 : col_r;
      CMD_TAB:   col_put = (col_r + COL_W'(TAB_STEP)) & ~COL_W'(TAB_STEP - 1);
      CMD_CR:    col_put = '0;
      CMD_LF: begin
        col_put = '0;
        row_put = row_r + 1'b1;
      end
      default: col_put = col_r;
    endcase
    if (32'(col_put) >= COLUMNS) begin
      col_put = '0;
      row_put = row_put + 1'b1;
    end
    need_scroll = 32'(row_put) >= ROWS;
    if (need_scroll) begin
      row_put = ROW_W'(ROWS - 1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd.kind)
            CMD_CLEAR: state_nxt = ST_FILL;
            CMD_READ:  state_nxt = ST_READ;
            default:   state_nxt = need_scroll ? ST_COPY : ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_COPY: begin
        if (32'(cnt_r) == CELLS - COLUMNS) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (32'(cnt_r) == CELLS - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    init_nxt     = init_r;
    scroll_nxt   = scroll_r;
    we           = 1'b0;
    waddr        = cnt_r;
    wdata        = fill_word;
    re           = 1'b0;
    raddr        = cnt_r;
    load         = 1'b0;
    out_data_nxt = '0;
    out_scr_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          cnt_nxt    = '0;
          scroll_nxt = 1'b0;
          if (q_cmd.kind == CMD_CLEAR) begin
            col_nxt = '0;
            row_nxt = '0;
          end else if (q_cmd.kind == CMD_READ) begin
            re    = 1'b1;
            raddr = ADDR_W'(q_cmd.cell_index);
          end else begin
            col_nxt    = col_put;
            row_nxt    = row_put;
            scroll_nxt = need_scroll;
            if (q_cmd.kind == CMD_PRINT) begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {attr_r, q_cmd.char_code};
            end
            load = !need_scroll;
          end
        end
      end
      ST_READ: begin
        load         = 1'b1;
        out_data_nxt = rdata_r;
      end
      ST_COPY: begin
        // read one row ahead, write the word fetched last cycle
        re    = 32'(cnt_r) < CELLS - COLUMNS;
        raddr = cnt_r + ADDR_W'(COLUMNS);
        we    = cnt_r != '0;
        waddr = cnt_r - 1'b1;
        wdata = rdata_r;
        if (32'(cnt_r) != CELLS - COLUMNS) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (32'(cnt_r) == CELLS - 1) begin
          init_nxt    = 1'b0;
          load        = !init_r;
          out_scr_nxt = scroll_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
    out_loc_nxt   = LOC_W'(32'(row_nxt) * COLUMNS + 32'(col_nxt));
    out_valid_nxt = (out_valid_r && !out_tready) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      init_r      <= 1'b1;
      scroll_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      init_r      <= init_nxt;
      scroll_r    <= scroll_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_loc_r  <= out_loc_nxt;
      out_data_r <= out_data_nxt;
      out_scr_r  <= out_scr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  `TCW_ASSERT_IMPL(a_load_slot_free, clk, rst_n, load, !out_valid_r || out_tready)
  `TCW_ASSERT_IMPL(a_col_range, clk, rst_n, state_r == ST_IDLE, 32'(col_r) < COLUMNS)
  `TCW_ASSERT_IMPL(a_row_range, clk, rst_n, state_r == ST_IDLE, 32'(row_r) < ROWS)
  `TCW_ASSERT_IMPL(a_init_no_result, clk, rst_n, init_r, !load && !q_pop)
  `TCW_ASSERT_IMPL(a_put_only_idle, clk, rst_n, q_pop && is_put, !re)

endmodule

// ===== rtl/text_console_writer.sv =====
// channel  | dir | tdata (low bit up)                                  | tuser
// in_      | in  | char_code[7:0] cell_index[18:8], zero pad to 24     | mode[1:0]
// out_     | out | cursor_location[10:0] read_data[26:11] scrolled[27] | -
// cfg_     | in  | cfg_wdata = attribute byte, written when cfg_we      | -
//
// Put without scroll: done in ST_IDLE; read: goes through ST_READ (registered screen RAM read).
// Scroll: ST_COPY moves the rows up through the RAM read port, then ST_FILL blanks the last row.
// Clear: one cell written per cycle on the single RAM write port.
// Reset: rst_n synchronous, active low; then a blanking pass over every cell with
//   in_tready low. cfg writes are taken throughout.
// A 2-word queue sits between decode and execute; out_tready low stalls the back end, then the front once it is full.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic [MODE_W-1:0] in_tuser,   // mode[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // cursor_location[10:0], read_data[26:11], scrolled[27]
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  logic init_busy;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/text_console_writer_test.sv =====
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * CELLS + 64;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_loc;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } console_reply_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;        // char_code[7:0], cell_index[18:8]
  logic [MODE_W-1:0] in_tuser = MODE_PUT;  // mode[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;            // cursor_location[10:0], read_data[26:11], scrolled[27]
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;

  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] attr_now;
  console_reply_t    awaited_replies [$];

  int mismatches;
  int n_sent;
  int n_reads;
  int n_clears;
  int n_scrolls;
  int n_attr_writes;
  int burst_left;
  int idle_pct;
  int ready_run;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  function automatic void fill_shadow(input logic [CELL_W-1:0] blank);
    foreach (shadow_screen[i]) shadow_screen[i] = blank;
  endfunction

  function automatic console_reply_t apply_command(input logic [MODE_W-1:0] mode,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [IDX_W-1:0] idx);
    console_reply_t r;
    r = '0;
    case (mode)
      MODE_PUT: begin
        if (ch == CH_BS && cur_col != 0) begin
          cur_col--;
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= CH_SPACE && ch <= CH_LAST_PRINT) begin
          shadow_screen[cur_row * COLUMNS + cur_col] = {attr_now, ch};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = {attr_now, CH_SPACE};
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: begin
        fill_shadow({attr_now, CH_SPACE});
        cur_col = 0;
        cur_row = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) r.read_data = shadow_screen[idx];
      end
      default: ;
    endcase
    r.cursor_loc = LOC_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  task automatic send_command(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx);
    console_reply_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 8);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {5'b0, idx, ch};
    do @(posedge clk); while (in_tready !== 1'b1);
    r = apply_command(mode, ch, idx);
    awaited_replies.push_back(r);
    n_sent++;
    n_scrolls += r.scrolled;
    if (mode == MODE_READ) n_reads++;
    if (mode == MODE_CLEAR) n_clears++;
  endtask

  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    wait_for_replies();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    attr_now = value;
    n_attr_writes++;
  endtask

  task automatic test_control_codes();
    send_command(MODE_READ, 8'h00, '0);
    send_command(MODE_READ, 8'h00, IDX_W'(CELLS - 1));
    send_command(MODE_READ, 8'h00, IDX_W'(CELLS));
    send_command(MODE_READ, 8'hFF, '1);
    send_command(MODE_PUT, CH_BS, '0);
    send_command(MODE_PUT, CH_SPACE, '0);
    send_command(MODE_PUT, CH_LAST_PRINT, '1);
    send_command(MODE_PUT, 8'h80, '0);
    send_command(MODE_PUT, 8'hFF, '0);
    send_command(MODE_PUT, 8'h00, '0);
    send_command(MODE_PUT, 8'h1F, '0);
    send_command(MODE_PUT, CH_BS, '0);
    send_command(MODE_PUT, CH_TAB, '0);
    send_command(MODE_PUT, CH_CR, '0);
    send_command(MODE_PUT, CH_LF, '0);
    send_command(MODE_NONE, 8'hFF, '1);
    send_command(MODE_READ, 8'h00, IDX_W'(1));
    // tab overshoot wraps to the next row
    repeat (10) send_command(MODE_PUT, CH_TAB, '0);
    send_command(MODE_CLEAR, 8'hFF, '1);
    send_command(MODE_READ, 8'h00, IDX_W'(1));
  endtask

  task automatic test_text_stream(input int count);
    int pick;
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_command(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                     IDX_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
      end else if (pick < 12) begin
        send_command(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, IDX_SPAN - 1)));
      end else if (pick < 13) begin
        send_command(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, IDX_SPAN - 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 64) ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST_PRINT));
        else if (pick < 78) ch = CH_LF;
        else if (pick < 82) ch = CH_CR;
        else if (pick < 87) ch = CH_TAB;
        else if (pick < 92) ch = CH_BS;
        else if (pick < 96) ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
        else ch = CHAR_W'($urandom_range(CH_LAST_PRINT + 1, 255));
        send_command(MODE_PUT, ch, IDX_W'($urandom_range(0, IDX_SPAN - 1)));
      end
      if ($urandom_range(0, 99) == 0) wait_for_replies();
    end
  endtask

  task automatic test_noise(input int count);
    int pick;
    logic [MODE_W-1:0] mode;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) mode = MODE_CLEAR;
      else if (pick == 1) mode = MODE_NONE;
      else if (pick < 6) mode = MODE_READ;
      else mode = MODE_PUT;
      send_command(mode, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, IDX_SPAN - 1)));
    end
  endtask

  always @(posedge clk) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (out_tready && $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b0;
      ready_run <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
      ready_run <= $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin
    console_reply_t want;
    logic [LOC_W-1:0] got_loc;
    logic [CELL_W-1:0] got_data;
    logic got_scroll;
    if (rst_n && out_tvalid && out_tready) begin
      got_loc = out_tdata[10:0];
      got_data = out_tdata[26:11];
      got_scroll = out_tdata[27];
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("%0t: unexpected word: loc %0d data %h scrolled %0d",
                   $time, got_loc, got_data, got_scroll);
      end else begin
        want = awaited_replies.pop_front();
        if (got_loc !== want.cursor_loc || got_data !== want.read_data ||
            got_scroll !== want.scrolled) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: expected loc %0d data %h scrolled %0d, got loc %0d data %h scrolled %0d",
                     $time, want.cursor_loc, want.read_data, want.scrolled,
                     got_loc, got_data, got_scroll);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("text_console_writer: mismatch");
      $finish;
    end
  end

  initial begin
    fill_shadow(RESET_BLANK);
    attr_now = RESET_ATTR;
    cur_col = 0;
    cur_row = 0;
    idle_pct = 40;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // blanking pass after reset
    while (in_tready !== 1'b1) @(posedge clk);

    test_control_codes();
    set_attribute(8'hFF);
    test_text_stream(170);
    idle_pct = 0;
    set_attribute(8'h00);
    test_text_stream(170);
    idle_pct = 60;
    set_attribute(ATTR_W'($urandom_range(1, 254)));
    test_noise(140);
    idle_pct = 30;
    set_attribute(ATTR_W'($urandom_range(0, 255)));
    test_text_stream(190);

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d commands: %0d reads, %0d clears, %0d scrolls",
             n_sent, n_reads, n_clears, n_scrolls);
    $display("%0d attribute settings, %0d mismatching words", n_attr_writes, mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
